// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, clocked on clk and disabled in reset
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/core/ascp_pkg.sv =====
// types and constants shared by the ascii integer field parser
`default_nettype none

package ascp_pkg;

  // base selection codes
  typedef enum logic [1:0] {
    BASE_AUTO = 2'd0,
    BASE_OCT  = 2'd1,
    BASE_DEC  = 2'd2,
    BASE_HEX  = 2'd3
  } base_t;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMATCH = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // configuration register indexes
  localparam int          CFG_IDX_W       = 8;
  localparam logic [7:0]  CFG_BASE_SELECT = 8'd0;
  localparam logic [7:0]  CFG_MAX_CHARS   = 8'd1;
  localparam logic [7:0]  CFG_RESULT_SIZE = 8'd2;
  localparam logic [7:0]  CFG_SIGNED      = 8'd3;
  localparam int          CFG_DATA_W      = 16;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  // stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  // live configuration
  typedef struct packed {
    base_t        base_select;
    logic [15:0]  max_field_chars;
    logic [1:0]   result_size;
    logic         signed_result;
  } cfg_t;

  // one classified request
  typedef struct packed {
    logic        eoi;    // end of input mark
    logic        blank;  // space, tab, lf, vt, ff, cr
    logic        sign;   // plus or minus
    logic        minus;  // minus
    logic        xchar;  // x or X
    logic        zero;   // digit zero
    logic        hexd;   // any hex digit
    logic [3:0]  dval;   // digit value when hexd
  } class_t;

endpackage

`default_nettype wire

// ===== rtl/core/ascp_front.sv =====
// front end: accepts text requests and classifies each character
`default_nettype none

module ascp_front (
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ascp_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] text_byte
  input  wire logic                            in_tuser,   // [0] end_of_input
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output ascp_pkg::class_t                     push_item
);
  import ascp_pkg::*;

  logic [7:0] c;

  assign c          = in_tdata[7:0];
  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

  // character classification
  always_comb begin
    push_item       = '0;
    push_item.eoi   = in_tuser;
    push_item.blank = (c == 8'd32) || (c inside {[8'd9:8'd13]});
    push_item.sign  = (c == "+") || (c == "-");
    push_item.minus = (c == "-");
    push_item.xchar = (c == "x") || (c == "X");
    push_item.zero  = (c == "0");
    if (c inside {["0":"9"]}) begin
      push_item.hexd = 1'b1;
      push_item.dval = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      push_item.hexd = 1'b1;
      push_item.dval = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      push_item.hexd = 1'b1;
      push_item.dval = 4'(c - 8'h37);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ascp_queue.sv =====
// short queue of classified requests between front and back
`default_nettype none

module ascp_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire ascp_pkg::class_t  push_item,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output ascp_pkg::class_t       pop_item
);
  import ascp_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  class_t             mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ascp_back.sv =====
// back end: field state machine, accumulator and result register
`default_nettype none

module ascp_back #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ascp_pkg::cfg_t                   cfg,
  input  wire logic                             q_valid,
  output logic                                  q_ready,
  input  wire ascp_pkg::class_t                 q_item,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ascp_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import ascp_pkg::*;

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // shift amount for the result width
  function automatic logic [2:0] res_size_sh(input logic [1:0] sz);
    res_size_sh = {1'b0, sz};
  endfunction

  // field state
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [COUNT_BITS-1:0]  pos_r, pos_nxt;
  logic                   minus_r, minus_nxt;
  logic                   sign_r, sign_nxt;
  logic                   hex_r, hex_nxt;
  logic                   digit_r, digit_nxt;
  base_t                  base_r, base_nxt;

  // result register
  logic                   res_valid_r;
  logic [VALUE_BITS-1:0]  res_acc_r;
  logic                   res_minus_r;
  logic [1:0]             res_status_r;
  logic                   res_consumed_r;

  // per-request decode
  logic                   emit, consumed, take;
  logic [VALUE_BITS-1:0]  e_acc;
  logic                   e_minus;
  logic [1:0]             e_status;
  logic                   pos0;
  base_t                  base_eff, base_dig;
  logic                   dig_ok;
  logic [VALUE_BITS+3:0]  ext, prod;
  logic [COUNT_BITS-1:0]  lead;

  assign take    = q_valid && q_ready;
  assign q_ready = !(emit && res_valid_r && !out_tready);
  assign pos0    = (pos_r == '0);
  assign lead    = {{(COUNT_BITS-1){1'b0}}, sign_r};

  // multiply-accumulate by 8, 10 or 16 with overflow detect
  always_comb begin
    ext = {4'b0000, acc_r};
    case (base_dig)
      BASE_OCT: prod = (ext << 3) + (VALUE_BITS+4)'(q_item.dval);
      BASE_DEC: prod = (ext << 3) + (ext << 1) + (VALUE_BITS+4)'(q_item.dval);
      default:  prod = (ext << 4) + (VALUE_BITS+4)'(q_item.dval);
    endcase
  end

  // field step
  always_comb begin
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    minus_nxt = minus_r;
    sign_nxt  = sign_r;
    hex_nxt   = hex_r;
    digit_nxt = digit_r;
    base_nxt  = base_r;
    emit      = 1'b0;
    consumed  = 1'b0;
    e_acc     = acc_r;
    e_minus   = minus_r;
    e_status  = digit_r ? ST_OK : ST_NOMATCH;
    base_eff  = pos0 ? cfg.base_select : base_r;
    base_dig  = base_eff;
    dig_ok    = 1'b0;

    if (q_item.eoi) begin
      emit = 1'b1;
      if (!digit_r) begin
        e_status = pos0 ? ST_EMPTY : ST_NOMATCH;
      end
    end else if (pos0 && q_item.blank) begin
      base_nxt = cfg.base_select;
    end else begin
      base_nxt = base_eff;
      if (q_item.sign && pos0) begin
        minus_nxt = q_item.minus;
        sign_nxt  = 1'b1;
      end else if (q_item.xchar && (base_eff == BASE_AUTO || base_eff == BASE_HEX) &&
                   pos_r == lead + COUNT_BITS'(1) && acc_r == '0) begin
        hex_nxt   = 1'b1;
        digit_nxt = 1'b0;
      end else if (q_item.zero && pos_r == lead) begin
        acc_nxt   = '0;
        digit_nxt = 1'b1;
      end else begin
        // resolve automatic base at the first significant digit
        if (base_eff == BASE_AUTO) begin
          if (hex_r) begin
            base_dig = BASE_HEX;
          end else begin
            base_dig = digit_r ? BASE_OCT : BASE_DEC;
          end
        end
        case (base_dig)
          BASE_OCT: dig_ok = q_item.hexd && (q_item.dval < 4'd8);
          BASE_DEC: dig_ok = q_item.hexd && (q_item.dval < 4'd10);
          default:  dig_ok = q_item.hexd;
        endcase
        if (!dig_ok) begin
          emit = 1'b1;
        end else begin
          base_nxt  = base_dig;
          acc_nxt   = (prod[VALUE_BITS+3:VALUE_BITS] != 4'b0000) ? '1 :
                      prod[VALUE_BITS-1:0];
          digit_nxt = 1'b1;
        end
      end
      // position count and width limit
      if (!emit) begin
        if (pos_r != '1) begin
          pos_nxt = pos_r + 1'b1;
        end
        if (cfg.max_field_chars != '0 &&
            CMP_W'(pos_nxt) >= CMP_W'(cfg.max_field_chars)) begin
          emit     = 1'b1;
          consumed = 1'b1;
          e_acc    = acc_nxt;
          e_minus  = minus_nxt;
          e_status = digit_nxt ? ST_OK : ST_NOMATCH;
        end
      end
    end

    // rearm after a field ends
    if (emit) begin
      acc_nxt   = '0;
      pos_nxt   = '0;
      minus_nxt = 1'b0;
      sign_nxt  = 1'b0;
      hex_nxt   = 1'b0;
      digit_nxt = 1'b0;
      base_nxt  = cfg.base_select;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      pos_r   <= '0;
      minus_r <= 1'b0;
      sign_r  <= 1'b0;
      hex_r   <= 1'b0;
      digit_r <= 1'b0;
      base_r  <= BASE_AUTO;
    end else if (take) begin
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      minus_r <= minus_nxt;
      sign_r  <= sign_nxt;
      hex_r   <= hex_nxt;
      digit_r <= digit_nxt;
      base_r  <= base_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take && emit) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_acc_r      <= e_acc;
      res_minus_r    <= e_minus;
      res_status_r   <= e_status;
      res_consumed_r <= consumed;
    end
  end

  // negate, truncate to result size and extend
  logic [VALUE_BITS-1:0] mag;
  logic [63:0]           valx, val64;
  logic [6:0]            wsel, w;
  logic                  sbit;

  always_comb begin
    mag  = res_minus_r ? (VALUE_BITS'(0) - res_acc_r) : res_acc_r;
    valx = 64'(mag);
    wsel = 7'd8 << res_size_sh(cfg.result_size);
    w    = (wsel > 7'(VALUE_BITS)) ? 7'(VALUE_BITS) : wsel;
    sbit = valx[6'(w - 7'd1)];
    for (int i = 0; i < 64; i++) begin
      val64[i] = (7'(i) < w) ? valx[i] : (cfg.signed_result & sbit);
    end
    if (res_status_r != ST_OK) begin
      val64 = '0;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {5'b00000, res_consumed_r, res_status_r, val64};

endmodule

`default_nettype wire

// ===== rtl/core/ascii_integer_field_parser_core.sv =====
// top level of the ascii integer field parser
`default_nettype none

// Parses one scanf-style integer field from a stream of text bytes, one byte
// per in_ request, with in_tuser marking end of input. Leading whitespace is
// skipped, an optional sign and 0x prefix are honored, the magnitude saturates
// at 2^VALUE_BITS-1, and one out_ request carries value, status and the
// consumed flag when the field ends; the parser then rearms on its own.
// Throughput is one byte per clock while out_ is not stalled: the accumulator
// update (a shift, add and overflow check) in the back end is combinational,
// and a two-entry queue decouples the classifier from it. A byte that ends a
// field waits in the back end only while the previous result is still held on
// out_ with out_tready low; in_tready drops once the queue is full. With the
// queue empty and the result register free, the byte ending the field passes
// through the queue storage and then the result register, which drives
// out_tvalid. Configuration writes are taken at any time with cfg_ready held
// high and should be made only while idle; no clearing pass follows reset.
module ascii_integer_field_parser_core #(
  parameter int VALUE_BITS = 64,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // text input
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [ascp_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] text_byte
  input  wire logic                              in_tuser,   // [0] end_of_input
  // results
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [63:0] parsed_value, [65:64] status, [66] last_byte_consumed, [71:67] zero
  output logic [ascp_pkg::OUT_DATA_W-1:0]        out_tdata,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ascp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ascp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ascp_pkg::*;

  cfg_t    cfg_r;
  logic    push_valid, push_ready;
  class_t  push_item;
  logic    q_valid, q_ready;
  class_t  q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_select     <= BASE_AUTO;
      cfg_r.max_field_chars <= '0;
      cfg_r.result_size     <= 2'd3;
      cfg_r.signed_result   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_SELECT: cfg_r.base_select     <= base_t'(cfg_wdata[1:0]);
        CFG_MAX_CHARS:   cfg_r.max_field_chars <= cfg_wdata[15:0];
        CFG_RESULT_SIZE: cfg_r.result_size     <= cfg_wdata[1:0];
        CFG_SIGNED:      cfg_r.signed_result   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // classifier
  ascp_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decoupling queue
  ascp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  // field parser
  ascp_back #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // checks
  `include "assert_macros.svh"

  `ASSERT_IMPLIES(a_fail_zero, out_tvalid && out_tdata[65:64] != ST_OK, out_tdata[63:0] == '0, "failed field value")
  `ASSERT_IMPLIES(a_full_nonempty, !in_tready, q_valid, "queue full but empty")
  `ASSERT_NEXT(a_eoi_result, q_valid && q_ready && q_item.eoi, out_tvalid, "end of input gave no result")

endmodule

`default_nettype wire

// ===== tb/tb_ascii_integer_field_parser_core.sv =====
// testbench for the ascii integer field parser: directed and random text streams checked against a predictor
`timescale 1ns / 1ps

module tb_ascii_integer_field_parser_core;
  import ascp_pkg::*;

  localparam int VALUE_BITS = 64;
  localparam int COUNT_BITS = 16;
  localparam logic [63:0] VMAX = {64{1'b1}} >> (64 - VALUE_BITS);
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // one expected result of a field
  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic        consumed;
  } field_result_t;

  // predicts parser results and checks them in order
  class field_scoreboard;
    base_t                 base_sel;
    logic [15:0]           max_chars;
    logic [1:0]            res_size;
    logic                  sign_ext;
    logic [63:0]           acc;
    logic [COUNT_BITS-1:0] pos;
    logic                  minus_flag;
    logic                  sign_flag;
    logic                  hex_prefix;
    logic                  digit_flag;
    base_t                 field_base;
    field_result_t         expected_fields[$];
    int                    errors;

    function new();
      base_sel  = BASE_AUTO;
      max_chars = '0;
      res_size  = 2'd3;
      sign_ext  = 1'b1;
      errors    = 0;
      rearm();
    endfunction

    function void rearm();
      acc        = '0;
      pos        = '0;
      minus_flag = 1'b0;
      sign_flag  = 1'b0;
      hex_prefix = 1'b0;
      digit_flag = 1'b0;
      field_base = base_sel;
    endfunction

    function int radix_of(base_t b);
      case (b)
        BASE_OCT: return 8;
        BASE_DEC: return 10;
        BASE_HEX: return 16;
        default:  return 0;
      endcase
    endfunction

    function int digit_val(logic [7:0] c, int radix);
      int v;
      v = -1;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 10;
      else if (c >= "A" && c <= "F") v = c - "A" + 10;
      if (v >= radix) return -1;
      return v;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == CFG_BASE_SELECT) base_sel = base_t'(data[1:0]);
      else if (idx == CFG_MAX_CHARS) max_chars = data;
      else if (idx == CFG_RESULT_SIZE) res_size = data[1:0];
      else if (idx == CFG_SIGNED) sign_ext = data[0];
    endfunction

    // close the field and queue its result
    function void close_field(logic consumed, logic at_end);
      field_result_t r;
      int            w;
      logic [63:0]   m;
      r.value    = '0;
      r.consumed = consumed;
      if (digit_flag) begin
        r.status = ST_OK;
        r.value  = acc & VMAX;
        if (minus_flag) r.value = (64'd0 - r.value) & VMAX;
        w = 8 << res_size;
        if (w > VALUE_BITS) w = VALUE_BITS;
        m = {64{1'b1}} >> (64 - w);
        r.value &= m;
        if (sign_ext && r.value[w-1]) r.value |= ~m;
      end else begin
        r.status = (at_end && pos == 0) ? ST_EMPTY : ST_NOMATCH;
      end
      expected_fields.push_back(r);
      rearm();
    endfunction

    // advance the field state by one accepted request
    function void parse_byte(logic [7:0] c, logic eoi);
      logic [COUNT_BITS-1:0] lead;
      int                    rdx;
      int                    d;
      logic [63:0]           du;
      if (eoi) begin
        close_field(1'b0, 1'b1);
        return;
      end
      if (pos == 0) begin
        field_base = base_sel;
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) return;
      end
      lead = COUNT_BITS'(sign_flag);
      if ((c == "-" || c == "+") && pos == 0) begin
        minus_flag = (c == "-");
        sign_flag  = 1'b1;
      end else if ((c == "x" || c == "X") && (field_base == BASE_AUTO || field_base == BASE_HEX)
                   && pos == lead + 1 && acc == 0) begin
        hex_prefix = 1'b1;
        digit_flag = 1'b0;
      end else if (c == "0" && pos == lead) begin
        acc        = '0;
        digit_flag = 1'b1;
      end else begin
        if (field_base == BASE_AUTO) begin
          if (hex_prefix) begin
            if (digit_val(c, 16) < 0) begin
              close_field(1'b0, 1'b0);
              return;
            end
            field_base = BASE_HEX;
          end else begin
            field_base = digit_flag ? BASE_OCT : BASE_DEC;
          end
        end
        rdx = radix_of(field_base);
        d   = digit_val(c, rdx);
        if (d < 0) begin
          close_field(1'b0, 1'b0);
          return;
        end
        du = 64'(d);
        // saturate the magnitude
        if (acc > (VMAX - du) / 64'(rdx)) acc = VMAX;
        else acc = acc * 64'(rdx) + du;
        digit_flag = 1'b1;
      end
      if (pos != CMAX) pos++;
      if (max_chars != 0 && pos >= max_chars) close_field(1'b1, 1'b0);
    endfunction

    function void check_field(logic [OUT_DATA_W-1:0] d);
      field_result_t want;
      if (expected_fields.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, d);
        errors++;
        return;
      end
      want = expected_fields.pop_front();
      if (d[63:0] !== want.value) begin
        $display("%0t: parsed_value expected %h actual %h", $time, want.value, d[63:0]);
        errors++;
      end
      if (d[65:64] !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, d[65:64]);
        errors++;
      end
      if (d[66] !== want.consumed) begin
        $display("%0t: last_byte_consumed expected %0d actual %0d", $time, want.consumed, d[66]);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  field_scoreboard sb = new();
  int burst_left = 0;
  int item_count = 0;
  bit ready_mode = 1'b0;
  int ready_run = 0;

  ascii_integer_field_parser_core #(
    .VALUE_BITS(VALUE_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always #2 clk = ~clk;

  // result side: check accepted results, stall in runs
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_field(out_tdata);
    if (ready_run == 0) begin
      ready_mode = !ready_mode;
      ready_run  = ready_mode ? $urandom_range(1, 12) : $urandom_range(1, 5);
      if (ready_mode && $urandom_range(0, 9) == 0) ready_run = 300;
    end
    ready_run--;
    out_tready <= ready_mode;
  end

  // send one request, in bursts with random gaps between them
  task automatic send_item(input logic [7:0] b, input logic eoi);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    item_count++;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eoi;
    do @(posedge clk); while (!in_tready);
    sb.parse_byte(b, eoi);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // stop sending and wait until every pending field result has arrived
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.expected_fields.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_fields.size() != 0) begin
      $display("%0t: %0d results missing, expected %h actual none", $time,
               sb.expected_fields.size(), sb.expected_fields[0]);
      sb.errors++;
      sb.expected_fields.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [7:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] blank_char();
    int v;
    v = $urandom_range(8, 13);
    return (v == 8) ? 8'd32 : 8'(v);
  endfunction

  function automatic logic [7:0] digit_char(int rdx);
    int v;
    v = $urandom_range(0, rdx - 1);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  // one random field: mostly well formed, some noise
  task automatic send_field();
    int rdx;
    int ndig;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 4))
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      return;
    end
    repeat ($urandom_range(0, 2)) send_item(blank_char(), 1'b0);
    if ($urandom_range(0, 2) == 0) send_item($urandom_range(0, 1) ? "-" : "+", 1'b0);
    rdx = sb.radix_of(sb.base_sel);
    case ($urandom_range(0, 3))
      0: begin
        send_item("0", 1'b0);
        send_item($urandom_range(0, 1) ? "x" : "X", 1'b0);
        if (rdx == 0) rdx = 16;
      end
      1: begin
        send_item("0", 1'b0);
        if (rdx == 0) rdx = 8;
      end
      default: if (rdx == 0) rdx = 10;
    endcase
    // now and then digits outside the base
    if ($urandom_range(0, 9) == 0) rdx = ($urandom_range(0, 1) == 0) ? 16 : 10;
    ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 26) : $urandom_range(0, 6);
    repeat (ndig) send_item(digit_char(rdx), 1'b0);
    case ($urandom_range(0, 4))
      0: send_item(blank_char(), 1'b0);
      1: send_item(8'($urandom_range(0, 255)), 1'b0);
      2: send_item(8'($urandom_range(0, 255)), 1'b1);
      3: ;
      default: send_item(",", 1'b0);
    endcase
  endtask

  // main sequence
  initial begin
    int phase_no;
    logic [15:0] limit;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed fields with reset settings
    send_text(" \t-0x1F,");
    send_text("0xg");
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_text("0179");
    send_text("+");
    send_item(8'($urandom_range(0, 255)), 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    settle();

    // hex, width limit, narrow unsigned result
    cfg_write(CFG_BASE_SELECT, 16'(BASE_HEX));
    cfg_write(CFG_MAX_CHARS, 16'd3);
    cfg_write(CFG_RESULT_SIZE, 16'd0);
    cfg_write(CFG_SIGNED, 16'd0);
    send_text("-fF7");
    send_item(8'($urandom_range(0, 255)), 1'b1);
    settle();

    // long field: the value saturates, then the limit is lowered mid-field
    cfg_write(CFG_BASE_SELECT, 16'(BASE_DEC));
    cfg_write(CFG_MAX_CHARS, 16'd0);
    cfg_write(CFG_RESULT_SIZE, 16'd3);
    cfg_write(CFG_SIGNED, 16'd1);
    send_text(",-");
    repeat (40) send_item(digit_char(10), 1'b0);
    settle();
    cfg_write(CFG_MAX_CHARS, 16'd30);
    send_item(digit_char(10), 1'b0);
    settle();

    // random phases, each with its own settings
    phase_no = 0;
    while (item_count < 1050) begin
      case ((phase_no < 6) ? phase_no : $urandom_range(0, 5))
        0: limit = 16'd65535;
        1: limit = 16'd1;
        2: limit = 16'd0;
        3: limit = 16'($urandom_range(2, 8));
        4: limit = 16'($urandom_range(9, 30));
        default: limit = 16'($urandom_range(0, 65535));
      endcase
      cfg_write(CFG_BASE_SELECT, 16'($urandom_range(0, 65535)));
      cfg_write(CFG_MAX_CHARS, limit);
      cfg_write(CFG_RESULT_SIZE, 16'($urandom_range(0, 65535)));
      cfg_write(CFG_SIGNED, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0)
        cfg_write(8'($urandom_range(4, 255)), 16'($urandom_range(0, 65535)));
      repeat ($urandom_range(4, 12)) send_field();
      settle();
      phase_no++;
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
